### hdl/scic_pkg.sv
// ----------------------------------------------------------------------------
// Sector checksum integrity checker package
// Shared widths, codes, payload structs and the command passed front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package scic_pkg;

    localparam int SECTORS_DEFAULT = 4096;
    localparam int FIFO_DEPTH      = 4;

    localparam int SECTOR_W   = 32;
    localparam int SUM_W      = 64;
    localparam int COUNT_W    = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int ENTRY_W    = SUM_W + 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRITY_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR_COUNT     = 1'b1;

    localparam logic [COUNT_W-1:0] SECTOR_COUNT_RESET = 13'h1000;

    typedef enum logic [1:0] {
        OP_WRITE_SUBMIT   = 2'd0,
        OP_WRITE_COMPLETE = 2'd1,
        OP_READ_COMPLETE  = 2'd2,
        OP_READ_SUBMIT    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_MATCH    = 3'd1,
        ST_MISMATCH = 3'd2,
        ST_NO_ENTRY = 3'd3,
        ST_IGNORED  = 3'd4
    } status_t;

    // what the back end does with a finished sector
    typedef enum logic [1:0] {
        CMD_IGNORE      = 2'd0,
        CMD_STORE       = 2'd1,
        CMD_CHECK       = 2'd2,
        CMD_CHECK_STORE = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        op_t                 operation;
        logic [SECTOR_W-1:0] sector;
        logic [SUM_W-1:0]    data_word;
        logic                last_word;
    } in_item_t;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector_out;
        status_t             status;
        logic [SUM_W-1:0]    computed_sum;
        logic [SUM_W-1:0]    stored_sum;
    } out_item_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [SECTOR_W-1:0] sector;
        logic [SUM_W-1:0]    sum;
    } cmd_t;

    typedef struct packed {
        logic               integrity_enable;
        logic [COUNT_W-1:0] sector_count;
    } cfg_t;

endpackage

`default_nettype wire

### hdl/scic_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one read port, read data registered, read-before-write.
// ----------------------------------------------------------------------------
`default_nettype none

module scic_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hdl/scic_fifo.sv
// ----------------------------------------------------------------------------
// Command queue
// Short register queue decoupling the summing front from the table back end.
// ----------------------------------------------------------------------------
`default_nettype none

module scic_fifo
    import scic_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire cmd_t push_cmd,
    output logic      pop_valid,
    input  wire logic pop,
    output cmd_t      pop_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

### hdl/scic_front.sv
// ----------------------------------------------------------------------------
// Summing front end
// Accumulate data words and classify each finished sector into a command.
// ----------------------------------------------------------------------------
`default_nettype none

module scic_front
    import scic_pkg::*;
#(
    parameter int SECTORS = SECTORS_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_data,
    input  wire cfg_t     cfg,
    input  wire logic     clearing,
    output logic          push_valid,
    input  wire logic     push_ready,
    output cmd_t          push_cmd
);

    logic [SUM_W-1:0] running_sum_reg, running_sum_next;
    logic [SUM_W-1:0] sum_now;
    logic             accept;
    logic             tracked;

    assign in_stall = clearing || !push_ready;
    assign accept   = in_valid && !in_stall;
    assign sum_now  = running_sum_reg + in_data.data_word;

    assign tracked = cfg.integrity_enable
                  && (in_data.sector < {{(SECTOR_W - COUNT_W){1'b0}}, cfg.sector_count})
                  && (in_data.sector < SECTOR_W'(SECTORS));

    always_comb
    begin
        push_cmd.sector = in_data.sector;
        push_cmd.sum    = sum_now;
        push_cmd.kind   = CMD_IGNORE;
        if (tracked)
        begin
            unique case (in_data.operation)
                OP_WRITE_SUBMIT:   push_cmd.kind = CMD_STORE;
                OP_WRITE_COMPLETE: push_cmd.kind = CMD_CHECK;
                OP_READ_COMPLETE:  push_cmd.kind = CMD_CHECK_STORE;
                default:           push_cmd.kind = CMD_IGNORE;
            endcase
        end
    end

    assign push_valid = accept && in_data.last_word;

    always_comb
    begin
        running_sum_next = running_sum_reg;
        if (accept)
        begin
            running_sum_next = in_data.last_word ? '0 : sum_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg <= '0;
        end
        else
        begin
            running_sum_reg <= running_sum_next;
        end
    end

endmodule

`default_nettype wire

### hdl/scic_back.sv
// ----------------------------------------------------------------------------
// Table back end
// Clear the checksum table, then look up, compare and update per sector.
// ----------------------------------------------------------------------------
`default_nettype none

module scic_back
    import scic_pkg::*;
#(
    parameter int SECTORS = SECTORS_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic pop_valid,
    output logic      pop,
    input  wire cmd_t pop_cmd,
    output logic      clearing,
    output logic      out_valid,
    input  wire logic out_stall,
    output out_item_t out_data
);

    localparam int IDX_W = (SECTORS > 1) ? $clog2(SECTORS) : 1;
    localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(SECTORS - 1);

    logic               clearing_reg;
    logic [IDX_W-1:0]   clr_idx_reg;

    logic               b_valid_reg;
    cmd_t               b_cmd_reg;
    logic               fwd_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;

    logic               out_valid_reg;
    out_item_t          out_reg, out_next;

    logic               b_retire;
    logic               b_we;
    logic [IDX_W-1:0]   b_idx;
    logic [IDX_W-1:0]   r_idx;
    logic [ENTRY_W-1:0] b_wdata;
    logic [ENTRY_W-1:0] rdata;
    logic [ENTRY_W-1:0] entry;
    logic               entry_ok;
    logic [SUM_W-1:0]   entry_sum;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;

    assign clearing  = clearing_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign b_retire = b_valid_reg && (!out_valid_reg || !out_stall);
    assign pop      = pop_valid && !clearing_reg && (!b_valid_reg || b_retire);

    assign b_idx   = b_cmd_reg.sector[IDX_W-1:0];
    assign r_idx   = pop_cmd.sector[IDX_W-1:0];
    assign b_we    = b_retire
                  && (b_cmd_reg.kind == CMD_STORE || b_cmd_reg.kind == CMD_CHECK_STORE);
    assign b_wdata = {1'b1, b_cmd_reg.sum};

    // the entry written by the retiring command has not reached the read data yet
    assign entry     = fwd_reg ? fwd_data_reg : rdata;
    assign entry_ok  = entry[ENTRY_W-1];
    assign entry_sum = entry[SUM_W-1:0];

    assign ram_we    = clearing_reg || b_we;
    assign ram_waddr = clearing_reg ? clr_idx_reg : b_idx;
    assign ram_wdata = clearing_reg ? '0 : b_wdata;

    scic_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SECTORS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (pop),
        .raddr (r_idx),
        .rdata (rdata)
    );

    always_comb
    begin
        out_next.sector_out   = b_cmd_reg.sector;
        out_next.computed_sum = b_cmd_reg.sum;
        out_next.stored_sum   = entry_ok ? entry_sum : '0;
        out_next.status       = ST_IGNORED;
        case (b_cmd_reg.kind) inside
            CMD_STORE:
            begin
                out_next.status = ST_STORED;
            end
            CMD_CHECK, CMD_CHECK_STORE:
            begin
                if (!entry_ok)
                begin
                    out_next.status = ST_NO_ENTRY;
                end
                else if (entry_sum == b_cmd_reg.sum)
                begin
                    out_next.status = ST_MATCH;
                end
                else
                begin
                    out_next.status = ST_MISMATCH;
                end
            end
            default:
            begin
                out_next.status     = ST_IGNORED;
                out_next.stored_sum = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            b_valid_reg   <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == CLR_LAST)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (pop)
            begin
                b_valid_reg <= 1'b1;
                fwd_reg     <= b_we && (b_idx == r_idx);
            end
            else if (b_retire)
            begin
                b_valid_reg <= 1'b0;
            end
            if (b_retire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b_cmd_reg    <= pop_cmd;
            fwd_data_reg <= b_wdata;
        end
        if (b_retire)
        begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !pop)
        else $error("command taken during table clearing pass");

    a_forward_on_hazard: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && b_we && (b_idx == r_idx)) |=> fwd_reg)
        else $error("read-after-write hazard not forwarded");

    a_clear_covers_table: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clearing_reg) |-> ($past(clr_idx_reg) == CLR_LAST))
        else $error("clearing pass ended before the last entry");

    a_write_only_on_retire: assert property (@(posedge clk) disable iff (!rst_n)
        b_we |-> (b_valid_reg && !clearing_reg && (!out_valid_reg || !out_stall)))
        else $error("table written without a retiring command");
`endif

endmodule

`default_nettype wire

### hdl/sector_checksum_integrity_checker.sv
// ----------------------------------------------------------------------------
// Sector checksum integrity checker
// Per-sector additive checksum tracking and checking over a word stream.
// ----------------------------------------------------------------------------
// Sector data arrives one 64-bit word per transfer and is added modulo 2^64;
// the transfer flagged last_word closes the sector and produces exactly one
// result, other transfers produce none. The block takes one input transfer
// per clock cycle while in_stall is low and delivers up to one result per cycle;
// each result passes through the command queue, the lookup register and the
// result register. The per-sector table sits in one RAM (checksum plus valid
// bit) read once per sector with registered read data; a write by the command
// ahead of the current one is forwarded around the RAM read. After reset a
// clearing pass sweeps all SECTORS table entries one entry per cycle, with
// in_stall held high; configuration writes are taken throughout. Configuration
// must only be changed with no sector in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module sector_checksum_integrity_checker
    import scic_pkg::*;
#(
    parameter int SECTORS = SECTORS_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_data,

    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_data,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;
    logic clearing;
    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop;
    cmd_t pop_cmd;

    // Accept every configuration transfer at once.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.integrity_enable <= 1'b0;
            cfg_reg.sector_count     <= SECTOR_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_INTEGRITY_ENABLE: cfg_reg.integrity_enable <= cfg_data[0];
                REG_SECTOR_COUNT:     cfg_reg.sector_count     <= cfg_data[COUNT_W-1:0];
                default:              ;
            endcase
        end
    end

    // Front: sum the words and classify the closed sector.
    scic_front #(
        .SECTORS (SECTORS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .cfg        (cfg_reg),
        .clearing   (clearing),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // Queue: hold commands so that an output stall does not stop the word stream at once.
    scic_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_cmd    (pop_cmd)
    );

    // Back: table lookup, compare, update and the result register.
    scic_back #(
        .SECTORS (SECTORS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_cmd   (pop_cmd),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

### tb/sector_sum_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sector checksum checker
// Watches the input, result and register channels of the integrity checker,
// keeps its own copy of the checksum table and compares every result with
// the one predicted for the closing word of each sector.
// ----------------------------------------------------------------------------
module sector_sum_checker
    import scic_pkg::*;
#(
    parameter int SECTORS = SECTORS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    input  logic                  in_stall,
    input  in_item_t              in_data,

    input  logic                  out_valid,
    input  logic                  out_stall,
    input  out_item_t             out_data,

    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    output int                    failures,
    output int                    pending,
    output int                    results_checked
);

    logic [SUM_W-1:0]   sum_table [SECTORS];
    logic               entry_valid [SECTORS];
    logic [SUM_W-1:0]   running_sum;
    logic               enable_copy;
    logic [COUNT_W-1:0] count_copy;

    out_item_t          expected_results [$];
    int                 error_total  = 0;
    int                 result_total = 0;

    initial
    begin
        failures        = 0;
        pending         = 0;
        results_checked = 0;
    end

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        begin
            if (want !== got)
            begin
                $display("%0t: %s differs: expected %0h, actual %0h",
                         $time, name, want, got);
                error_total++;
            end
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        begin
            result_total++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none outstanding: expected none, actual %0h",
                         $time, got);
                error_total++;
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("sector_out", {32'd0, want.sector_out},
                              {32'd0, got.sector_out});
                compare_field("status", {61'd0, want.status}, {61'd0, got.status});
                compare_field("computed_sum", want.computed_sum, got.computed_sum);
                compare_field("stored_sum", want.stored_sum, got.stored_sum);
            end
        end
    endtask

    // Fold one word into the running sum; the closing word acts on the table.
    task automatic fold_word(input in_item_t w);
        out_item_t        res;
        logic [SUM_W-1:0] total;
        int unsigned      idx;
        begin
            running_sum = running_sum + w.data_word;
            if (w.last_word)
            begin
                total            = running_sum;
                running_sum      = '0;
                res.sector_out   = w.sector;
                res.status       = ST_IGNORED;
                res.computed_sum = total;
                res.stored_sum   = '0;
                if (enable_copy && (w.sector < count_copy) && (w.sector < SECTORS))
                begin
                    idx = w.sector;
                    case (w.operation) inside
                        OP_WRITE_SUBMIT:
                        begin
                            res.stored_sum   = entry_valid[idx] ? sum_table[idx] : '0;
                            res.status       = ST_STORED;
                            sum_table[idx]   = total;
                            entry_valid[idx] = 1'b1;
                        end
                        OP_WRITE_COMPLETE, OP_READ_COMPLETE:
                        begin
                            if (entry_valid[idx])
                            begin
                                res.stored_sum = sum_table[idx];
                                res.status = (sum_table[idx] == total) ? ST_MATCH
                                                                       : ST_MISMATCH;
                            end
                            else
                                res.status = ST_NO_ENTRY;
                            if (w.operation == OP_READ_COMPLETE)
                            begin
                                sum_table[idx]   = total;
                                entry_valid[idx] = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                expected_results.push_back(res);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SECTORS; i++)
                entry_valid[i] = 1'b0;
            running_sum = '0;
            enable_copy = 1'b0;
            count_copy  = SECTOR_COUNT_RESET;
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            // results leave only after their word has passed the command queue, the lookup
            // register and the result register, so retiring before folding keeps the queue order
            if (out_valid && !out_stall)
                check_result(out_data);
            if (in_valid && !in_stall)
                fold_word(in_data);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_INTEGRITY_ENABLE: enable_copy = cfg_data[0];
                    REG_SECTOR_COUNT:     count_copy  = cfg_data[COUNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            pending         <= expected_results.size();
            failures        <= error_total;
            results_checked <= result_total;
        end
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sector checksum integrity checker testbench
// Drives sector word streams and register settings into the block under
// random idling on both channels; a side checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import scic_pkg::*;

    localparam int SEGMENTS          = 7;
    localparam int ITEMS_PER_SEGMENT = 265;
    localparam int DRAIN_CYCLES      = 8;
    // covers the table clearing pass after reset with plenty to spare
    localparam int WATCHDOG_LIMIT    = 20000;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int failures;
    int pending;
    int results_checked;

    // idling profile, in cycles of a hundred
    int send_gap_pct = 10;
    int stall_pct    = 58;

    int idle_cycles  = 0;
    int items_sent   = 0;

    // sectors revisited often, with the last sum stored for each, so that
    // completes can be aimed at a match
    logic [31:0]        hot_sector [16];
    logic [SUM_W-1:0]   hot_sum    [16];
    logic [COUNT_W-1:0] count_shadow = SECTOR_COUNT_RESET;

    sector_checksum_integrity_checker i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sector_sum_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .failures        (failures),
        .pending         (pending),
        .results_checked (results_checked)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Receiver: stall at random, one fresh decision per cycle.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Watchdog: end the run if no channel moves a transfer for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Present one word and hold it until the block takes the transfer.
    // Valid is left high afterwards, so back-to-back words need no dip.
    task automatic push_item(input op_t op, input logic [31:0] sector,
                             input logic [SUM_W-1:0] word, input logic last);
        in_item_t item;
        begin
            item.operation = op;
            item.sector    = sector;
            item.data_word = word;
            item.last_word = last;
            if ($urandom_range(99) < send_gap_pct)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(4, 1)) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= item;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            items_sent++;
        end
    endtask

    // Send a sector of the given length whose words add up to target.
    // Now and then a middle word carries another sector number or operation;
    // only the closing word's fields should count.
    task automatic send_sector(input op_t op, input logic [31:0] sector,
                               input int words, input logic [SUM_W-1:0] target);
        logic [SUM_W-1:0] partial;
        logic [SUM_W-1:0] word;
        logic [31:0]      tag;
        begin
            partial = '0;
            for (int k = 0; k < words - 1; k++)
            begin
                word = {$urandom, $urandom};
                tag  = ($urandom_range(9) == 0) ? $urandom : sector;
                push_item(($urandom_range(7) == 0) ? op_t'($urandom_range(3)) : op,
                          tag, word, 1'b0);
                partial = partial + word;
            end
            push_item(op, sector, target - partial, 1'b1);
        end
    endtask

    // Write one register; valid stays high for a following write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
    endtask

    // Write both registers; junk in the unused enable bits must be dropped.
    task automatic configure(input logic en, input logic [COUNT_W-1:0] count);
        logic [CFG_DATA_W-2:0] junk;
        begin
            junk = (CFG_DATA_W-1)'($urandom);
            write_reg(REG_INTEGRITY_ENABLE, {junk, en});
            write_reg(REG_SECTOR_COUNT, count);
            cfg_valid    <= 1'b0;
            count_shadow  = count;
        end
    endtask

    // Hold the sender until every expected result has arrived, then let the
    // pipeline settle. The first edge lets the checker's count catch up.
    task automatic drain();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (pending != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    initial
    begin
        int          seg_start;
        int          pick;
        int          h;
        int          words;
        bit          is_hot;
        bit          paused;
        op_t         op;
        logic [31:0] sector;
        logic [63:0] target;

        paused = 1'b0;
        hot_sector[0] = 32'd0;
        hot_sector[1] = 32'd1;
        hot_sector[2] = 32'd4095;
        hot_sector[3] = 32'd4094;
        for (int i = 4; i < 16; i++)
            hot_sector[i] = $urandom_range(4095);
        for (int i = 0; i < 16; i++)
            hot_sum[i] = {$urandom, $urandom};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Reset leaves checking disabled: expect ignored.
        send_sector(OP_WRITE_SUBMIT, 32'd0, 1, 64'h1234);
        drain();
        configure(1'b1, 13'd4096);
        // complete on an empty entry, with the largest word
        send_sector(OP_WRITE_COMPLETE, 32'd5, 1, '1);
        // read complete on an empty entry stores, so the next compare matches
        send_sector(OP_READ_COMPLETE, 32'd6, 1, 64'h0123_4567_89ab_cdef);
        send_sector(OP_WRITE_COMPLETE, 32'd6, 1, 64'h0123_4567_89ab_cdef);
        // sum wraps round to zero
        push_item(OP_WRITE_SUBMIT, 32'd0, '1, 1'b0);
        push_item(OP_WRITE_SUBMIT, 32'd0, 64'd1, 1'b1);
        send_sector(OP_WRITE_COMPLETE, 32'd0, 1, 64'd0);
        send_sector(OP_WRITE_COMPLETE, 32'd0, 1, 64'd1);
        // read submit only closes the sum
        send_sector(OP_READ_SUBMIT, 32'd0, 1, '1);
        // top tracked sector, then first sector past the table and the largest
        send_sector(OP_WRITE_SUBMIT, 32'd4095, 1, '1);
        send_sector(OP_WRITE_SUBMIT, 32'd4096, 1, 64'd5);
        send_sector(OP_WRITE_SUBMIT, '1, 1, '1);
        // sector number changes mid-sector: the closing word's number counts
        push_item(OP_WRITE_SUBMIT, 32'd7, 64'hdead_beef, 1'b0);
        push_item(OP_WRITE_SUBMIT, 32'd8, 64'h5555_aaaa_5555_aaaa, 1'b1);
        // read complete with a different sum: mismatch, then the new sum stands
        send_sector(OP_READ_COMPLETE, 32'd4095, 1, 64'd0);
        send_sector(OP_WRITE_COMPLETE, 32'd4095, 1, 64'd0);
        // overwrite an existing entry; the old value comes back
        send_sector(OP_WRITE_SUBMIT, 32'd0, 1, 64'h8000_0000_0000_0000);

        // Random part, one register setting per segment.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            drain();
            case (seg)
                0: configure(1'b1, 13'd4096);
                1: configure(1'b1, 13'd8191);
                2: configure(1'b1, 13'd0);
                3:
                begin
                    // swap the idling roles
                    send_gap_pct = 58;
                    stall_pct    = 10;
                    configure(1'b0, 13'd4096);
                end
                4: configure(1'b1, 13'd1);
                5:
                begin
                    // no idling from here on
                    send_gap_pct = 0;
                    stall_pct    = 0;
                    configure(1'b1, COUNT_W'($urandom_range(4095, 2)));
                end
                default: configure(1'b1, 13'd4096);
            endcase
            seg_start = items_sent;
            while (items_sent - seg_start < ITEMS_PER_SEGMENT)
            begin
                // hold off once mid-segment until the block has emptied
                if (seg == 1 && !paused &&
                    items_sent - seg_start >= ITEMS_PER_SEGMENT / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
                pick = $urandom_range(99);
                if (pick < 10)
                begin
                    // noise: any field, any value, closing or not
                    push_item(op_t'($urandom_range(3)), $urandom,
                              {$urandom, $urandom}, 1'($urandom_range(1)));
                end
                else
                begin
                    is_hot = 1'b0;
                    h      = $urandom_range(15);
                    pick   = $urandom_range(99);
                    if (pick < 50)
                    begin
                        is_hot = 1'b1;
                        sector = hot_sector[h];
                    end
                    else if (pick < 70)
                        sector = $urandom_range(4095);
                    else if (pick < 80)
                        sector = $urandom;
                    else if (pick < 95)
                        // either side of the tracked count
                        sector = {19'd0, count_shadow} + $urandom_range(2) - 1;
                    else
                        sector = 32'd4096 + $urandom_range(3) - 1;
                    op   = op_t'($urandom_range(3));
                    pick = $urandom_range(99);
                    if (pick < 85)
                        words = $urandom_range(6, 1);
                    else if (pick < 95)
                        words = 64;
                    else
                        words = $urandom_range(70, 7);
                    if (is_hot && $urandom_range(99) < 60)
                        target = hot_sum[h];
                    else
                        target = {$urandom, $urandom};
                    send_sector(op, sector, words, target);
                    if (is_hot && (op == OP_WRITE_SUBMIT || op == OP_READ_COMPLETE))
                        hot_sum[h] = target;
                end
            end
        end
        drain();

        $display("Summary: %0d input transfers, %0d results checked", items_sent,
                 results_checked);
        $display("Covered seven register settings and three idling profiles.");
        if (failures == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
